>>> rtl/core/bccd_pkg.sv
// Package with shared types and constants of the frame deframer.
package bccd_pkg;

   localparam int RING_DEPTH = 512;
   localparam int RING_AW = $clog2(RING_DEPTH);
   localparam logic [7:0] HDR_MARK = 8'h23;
   localparam int FRAME_EXTRA = 11;
   localparam int HDR_BYTES = 10;
   localparam int MAX_FRAMES = 46;
   localparam logic [7:0] TIMEOUT_RESET = 8'd100;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);
   localparam int RSP_WIDTH = 80;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;
   localparam logic KIND_FRAME = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_IMAGE_CODE = 1'b1;

   typedef logic [RING_AW-1:0]  ring_addr_type;
   typedef logic [QUEUE_AW-1:0] queue_addr_type;
   typedef logic [QUEUE_AW:0]   queue_count_type;

   typedef struct packed {
      logic       command;
      logic [7:0] rx_byte;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_HREAD,
      ST_HEVAL,
      ST_BODY,
      ST_FEVAL,
      ST_STATUS
   } state_type;

endpackage

>>> rtl/core/bccd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bccd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bccd_req_queue.sv
// Front queue that accepts and classifies incoming bytes and poll ticks.
module bccd_req_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tuser,
   output logic               item_valid,
   input  logic               item_pop,
   output bccd_pkg::item_type item
);

   bccd_pkg::item_type slot_ff [bccd_pkg::QUEUE_DEPTH];
   bccd_pkg::queue_addr_type  head_ff, head_in, tail_ff, tail_in;
   bccd_pkg::queue_count_type count_ff, count_in;
   logic           push, pop;

   always_comb begin
      push = req_tvalid && req_tready;
      pop = item_pop && item_valid;
      head_in = pop ? head_ff + bccd_pkg::queue_addr_type'(1) : head_ff;
      tail_in = push ? tail_ff + bccd_pkg::queue_addr_type'(1) : tail_ff;
      count_in = count_ff + bccd_pkg::queue_count_type'(push)
                 - bccd_pkg::queue_count_type'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[tail_ff] <= '{command: req_tuser, rx_byte: req_tdata};
      end
   end

   assign req_tready = count_ff != bccd_pkg::queue_count_type'(bccd_pkg::QUEUE_DEPTH);
   assign item_valid = count_ff != '0;
   assign item = slot_ff[head_ff];

endmodule

>>> rtl/core/bccd_engine.sv
// Back-end sequencer: ring buffer, frame scan, check, image tracking and results.
module bccd_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            item_valid,
   output logic                            item_pop,
   input  bccd_pkg::item_type              item,
   input  logic                            csr_wr_en,
   input  logic                            csr_index,
   input  logic [7:0]                      csr_wdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bccd_pkg::RSP_WIDTH-1:0]  rsp_tdata,
   output logic                            rsp_tuser,
   output logic                            rsp_tlast
);

   bccd_pkg::state_type state_ff, state_in;
   bccd_pkg::ring_addr_type rp_ff, rp_in, wp_ff, wp_in;
   logic          hdr_ff, hdr_in;
   logic [9:0]    total_ff, total_in;
   logic [7:0]    wait_ff, wait_in;
   logic [31:0]   img_ff, img_in;
   logic [7:0]    lseq_ff, lseq_in;
   logic [7:0]    fail_ff, fail_in;
   logic [7:0]    drop_ff, drop_in;
   logic          ovf_ff, ovf_in;
   logic [5:0]    nfr_ff, nfr_in;
   logic [9:0]    cnt_ff, cnt_in;
   logic          rdv_ff, rdv_in;
   logic [9:0]    ridx_ff, ridx_in;
   logic [7:0]    bcc_ff, bcc_in;
   logic          ok_ff, ok_in;
   logic [7:0]    hb_ff [bccd_pkg::HDR_BYTES];
   logic [7:0]    timeout_ff, code_ff;
   logic          ov_ff, ov_in;
   logic [bccd_pkg::RSP_WIDTH-1:0] od_ff, od_in;
   logic          ok_kind_ff, ok_kind_in, olast_ff, olast_in;

   logic          wr_en;
   bccd_pkg::ring_addr_type rd_addr, fill;
   logic [7:0]    rd_data;
   logic          hb_we;
   logic [3:0]    hb_idx;
   logic [16:0]   tot;
   logic          out_free;
   logic [31:0]   decl;
   logic [8:0]    plen;
   logic          seq_ok, is_img;
   logic [32:0]   sum;

   bccd_ram #(.WIDTH(8), .DEPTH(bccd_pkg::RING_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (item.rx_byte),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      fill = wp_ff - rp_ff;
      rd_addr = rp_ff + cnt_ff[bccd_pkg::RING_AW-1:0];
      out_free = !ov_ff || rsp_tready;
      tot = {1'b0, hb_ff[8], hb_ff[9]} + 17'(bccd_pkg::FRAME_EXTRA);
      decl = {hb_ff[3], hb_ff[4], hb_ff[5], hb_ff[6]};
      plen = 9'(total_ff - 10'(bccd_pkg::FRAME_EXTRA));
      is_img = hb_ff[2] == code_ff;
      seq_ok = hb_ff[7] == lseq_ff + 8'd1;
      sum = {1'b0, img_ff} + (seq_ok ? {24'd0, plen} : 33'd0);

      state_in = state_ff;
      rp_in = rp_ff; wp_in = wp_ff; hdr_in = hdr_ff; total_in = total_ff;
      wait_in = wait_ff; img_in = img_ff; lseq_in = lseq_ff; fail_in = fail_ff;
      drop_in = drop_ff; ovf_in = ovf_ff; nfr_in = nfr_ff; cnt_in = cnt_ff;
      rdv_in = 1'b0; ridx_in = cnt_ff; bcc_in = bcc_ff; ok_in = ok_ff;
      ov_in = ov_ff && !rsp_tready; od_in = od_ff;
      ok_kind_in = ok_kind_ff; olast_in = olast_ff;
      item_pop = 1'b0; wr_en = 1'b0; hb_we = 1'b0; hb_idx = ridx_ff[3:0];

      case (state_ff)
         bccd_pkg::ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.command == bccd_pkg::CMD_TICK) begin
                  state_in = bccd_pkg::ST_CHECK;
               end else if (fill == bccd_pkg::ring_addr_type'(bccd_pkg::RING_DEPTH - 1)) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  wp_in = wp_ff + bccd_pkg::ring_addr_type'(1);
               end
            end
         end
         bccd_pkg::ST_CHECK: begin
            if (!hdr_ff) begin
               if (fill <= bccd_pkg::ring_addr_type'(bccd_pkg::HDR_BYTES)) begin
                  state_in = bccd_pkg::ST_STATUS;
               end else begin
                  cnt_in = '0;
                  state_in = bccd_pkg::ST_HREAD;
               end
            end else if ({1'b0, fill} >= total_ff) begin
               hdr_in = 1'b0;
               cnt_in = 10'd2;
               bcc_in = '0;
               state_in = bccd_pkg::ST_BODY;
            end else if (wait_ff < timeout_ff) begin
               wait_in = wait_ff + 8'd1;
               state_in = bccd_pkg::ST_STATUS;
            end else begin
               hdr_in = 1'b0;
               drop_in = (drop_ff == 8'hFF) ? drop_ff : drop_ff + 8'd1;
               rp_in = rp_ff + bccd_pkg::ring_addr_type'(1);
            end
         end
         bccd_pkg::ST_HREAD: begin
            if (cnt_ff < 10'(bccd_pkg::HDR_BYTES)) begin
               rdv_in = 1'b1;
               cnt_in = cnt_ff + 10'd1;
            end
            if (rdv_ff) begin
               hb_we = 1'b1;
               if (ridx_ff == 10'(bccd_pkg::HDR_BYTES - 1)) begin
                  state_in = bccd_pkg::ST_HEVAL;
               end
            end
         end
         bccd_pkg::ST_HEVAL: begin
            if (hb_ff[0] == bccd_pkg::HDR_MARK && hb_ff[1] == bccd_pkg::HDR_MARK &&
                tot <= 17'(bccd_pkg::RING_DEPTH - 1)) begin
               hdr_in = 1'b1;
               total_in = tot[9:0];
               wait_in = '0;
            end else begin
               rp_in = rp_ff + bccd_pkg::ring_addr_type'(1);
            end
            state_in = bccd_pkg::ST_CHECK;
         end
         bccd_pkg::ST_BODY: begin
            if (cnt_ff < total_ff) begin
               rdv_in = 1'b1;
               cnt_in = cnt_ff + 10'd1;
            end
            if (rdv_ff) begin
               if (ridx_ff == total_ff - 10'd1) begin
                  ok_in = bcc_ff == rd_data;
                  state_in = bccd_pkg::ST_FEVAL;
               end else begin
                  bcc_in = bcc_ff ^ rd_data;
               end
            end
         end
         bccd_pkg::ST_FEVAL: begin
            if (ok_ff && nfr_ff < 6'(bccd_pkg::MAX_FRAMES)) begin
               if (out_free) begin
                  od_in = '0;
                  od_in[7:0] = hb_ff[2];
                  od_in[15:8] = hb_ff[7];
                  od_in[47:16] = decl;
                  od_in[56:48] = plen;
                  if (is_img) begin
                     if (seq_ok) begin
                        lseq_in = hb_ff[7];
                        od_in[57] = 1'b1;
                     end
                     if (sum == {1'b0, decl}) begin
                        od_in[58] = 1'b1;
                        img_in = '0;
                     end else if (sum > {1'b0, decl}) begin
                        od_in[59] = 1'b1;
                        img_in = '0;
                     end else begin
                        img_in = sum[31:0];
                     end
                  end
                  ov_in = 1'b1;
                  ok_kind_in = bccd_pkg::KIND_FRAME;
                  olast_in = 1'b0;
                  rp_in = rp_ff + total_ff[bccd_pkg::RING_AW-1:0];
                  nfr_in = nfr_ff + 6'd1;
                  state_in = bccd_pkg::ST_CHECK;
               end
            end else begin
               if (!ok_ff) begin
                  fail_in = (fail_ff == 8'hFF) ? fail_ff : fail_ff + 8'd1;
               end
               rp_in = rp_ff + bccd_pkg::ring_addr_type'(1);
               state_in = bccd_pkg::ST_CHECK;
            end
         end
         bccd_pkg::ST_STATUS: begin
            if (out_free) begin
               od_in = '0;
               od_in[67:60] = fail_ff;
               od_in[75:68] = drop_ff;
               od_in[76] = ovf_ff;
               ov_in = 1'b1;
               ok_kind_in = bccd_pkg::KIND_STATUS;
               olast_in = 1'b1;
               fail_in = '0;
               drop_in = '0;
               ovf_in = 1'b0;
               nfr_in = '0;
               state_in = bccd_pkg::ST_IDLE;
            end
         end
         default: state_in = bccd_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bccd_pkg::ST_IDLE;
         rp_ff <= '0; wp_ff <= '0; hdr_ff <= 1'b0; total_ff <= '0;
         wait_ff <= '0; img_ff <= '0; lseq_ff <= '0; fail_ff <= '0;
         drop_ff <= '0; ovf_ff <= 1'b0; nfr_ff <= '0; cnt_ff <= '0;
         rdv_ff <= 1'b0; ov_ff <= 1'b0;
         timeout_ff <= bccd_pkg::TIMEOUT_RESET;
         code_ff <= '0;
      end else begin
         state_ff <= state_in;
         rp_ff <= rp_in; wp_ff <= wp_in; hdr_ff <= hdr_in; total_ff <= total_in;
         wait_ff <= wait_in; img_ff <= img_in; lseq_ff <= lseq_in; fail_ff <= fail_in;
         drop_ff <= drop_in; ovf_ff <= ovf_in; nfr_ff <= nfr_in; cnt_ff <= cnt_in;
         rdv_ff <= rdv_in; ov_ff <= ov_in;
         if (csr_wr_en && csr_index == bccd_pkg::CSR_TIMEOUT) begin
            timeout_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == bccd_pkg::CSR_IMAGE_CODE) begin
            code_ff <= csr_wdata;
         end
      end
      ridx_ff <= ridx_in;
      bcc_ff <= bcc_in;
      ok_ff <= ok_in;
      od_ff <= od_in;
      ok_kind_ff <= ok_kind_in;
      olast_ff <= olast_in;
      if (hb_we) begin
         hb_ff[hb_idx] <= rd_data;
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;
   assign rsp_tuser = ok_kind_ff;
   assign rsp_tlast = olast_ff;

endmodule

>>> rtl/core/bcc_frame_deframer_with_resync.sv
// Top level of the header and block-check frame deframer with resync.
//
// The req channel carries transactions of two kinds, chosen by req_tuser:
// a received byte (req_tuser low, byte in req_tdata) or a poll tick.
// Transactions enter a four-entry queue; the back end takes them in order.
// A byte is stored in a 512-entry ring and yields no result.
// A tick scans the ring: each valid frame (at most 46 per tick) gives one
// rsp item, and a status transaction with rsp_tlast high closes the run.
// Scan cost is set by the single RAM read port: each byte hunted over
// costs a header read, and each checked frame a header read plus a read
// of the frame body for the block check.
// Bytes flow at one per cycle while the queue has room, with the back end
// finishing one item at a time.
// Reset clears pointers, counters and the queue; ring contents stay unset.
// When the receiver stalls, the result register holds and the scan waits;
// the queue keeps accepting until full. Configuration is written on csr_*.
// The csr port writes timeout_ticks at index 0 and image_data_code at 1.
module bcc_frame_deframer_with_resync (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // rx_byte[7:0]
   input  logic        req_tuser,  // command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // command_code[7:0], frame_number[15:8], declared_size[47:16],
   // payload_length[56:48], in_sequence[57], image_complete[58],
   // image_overrun[59], checksum_failures[67:60], timeout_drops[75:68],
   // ring_overflow[76], zero fill[79:77]
   output logic [79:0] rsp_tdata,
   output logic        rsp_tuser,  // kind
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic               item_valid;
   logic               item_pop;
   bccd_pkg::item_type item;

   bccd_req_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item)
   );

   bccd_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_pop   (item_pop),
      .item       (item),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> verif/bcc_frame_deframer_with_resync_test.sv
// Self-checking testbench for the frame deframer with resynchronization.
`timescale 1ns / 1ps

module bcc_frame_deframer_with_resync_test;

   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE_CYCLES = 200;

   typedef struct {
      logic        kind;
      logic [79:0] data;
      logic        last_flag;
   } result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_wr_en = 1'b0;
   logic        csr_index = 1'b0;
   logic [7:0]  csr_wdata = '0;

   result_type  expected_results[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   bit          hold_results = 1'b0;
   int          ready_mode = 0;

   // Predictor state.
   logic [7:0]  ring_mem [bccd_pkg::RING_DEPTH];
   int          wr_ptr, rd_ptr, frame_bytes, wait_ticks;
   bit          in_frame, overflow_flag;
   logic [31:0] image_count;
   logic [7:0]  last_seq, fail_count, drop_count, timeout_cfg, image_code_cfg;
   logic [7:0]  next_seq;

   bcc_frame_deframer_with_resync DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (cycle_count % 64 == 0) ready_mode <= $urandom_range(0, 2);
      if (hold_results) rsp_tready <= 1'b0;
      else if (ready_mode == 0) rsp_tready <= 1'b1;
      else if (ready_mode == 1) rsp_tready <= $urandom_range(0, 1);
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   task automatic report_mismatch(input string what, input logic [79:0] got,
                                  input logic [79:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      error_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata, '0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_tuser !== want.kind)
               report_mismatch("kind", 80'(rsp_tuser), 80'(want.kind));
            if (rsp_tlast !== want.last_flag)
               report_mismatch("last", 80'(rsp_tlast), 80'(want.last_flag));
            if (rsp_tdata[7:0] !== want.data[7:0])
               report_mismatch("command_code", 80'(rsp_tdata[7:0]), 80'(want.data[7:0]));
            if (rsp_tdata[15:8] !== want.data[15:8])
               report_mismatch("frame_number", 80'(rsp_tdata[15:8]), 80'(want.data[15:8]));
            if (rsp_tdata[47:16] !== want.data[47:16])
               report_mismatch("declared_size", 80'(rsp_tdata[47:16]),
                               80'(want.data[47:16]));
            if (rsp_tdata[56:48] !== want.data[56:48])
               report_mismatch("payload_length", 80'(rsp_tdata[56:48]),
                               80'(want.data[56:48]));
            if (rsp_tdata[59:57] !== want.data[59:57])
               report_mismatch("image flags", 80'(rsp_tdata[59:57]), 80'(want.data[59:57]));
            if (rsp_tdata[67:60] !== want.data[67:60])
               report_mismatch("checksum_failures", 80'(rsp_tdata[67:60]),
                               80'(want.data[67:60]));
            if (rsp_tdata[75:68] !== want.data[75:68])
               report_mismatch("timeout_drops", 80'(rsp_tdata[75:68]),
                               80'(want.data[75:68]));
            if (rsp_tdata[79:76] !== want.data[79:76])
               report_mismatch("ring_overflow", 80'(rsp_tdata[79:76]),
                               80'(want.data[79:76]));
         end
      end
   end

   function automatic int ring_fill();
      return (wr_ptr + bccd_pkg::RING_DEPTH - rd_ptr) % bccd_pkg::RING_DEPTH;
   endfunction

   function automatic logic [7:0] ring_at(input int offset);
      return ring_mem[(rd_ptr + offset) % bccd_pkg::RING_DEPTH];
   endfunction

   function automatic logic [7:0] sat_add(input logic [7:0] value);
      return (value == 8'hFF) ? value : value + 8'd1;
   endfunction

   task automatic predict_scan();
      result_type  res;
      int          frames, total, i;
      logic [7:0]  bcc, code, seq;
      logic [31:0] declared;
      logic [32:0] sum;
      bit          inseq, done, over;
      frames = 0;
      forever begin
         if (!in_frame) begin
            if (ring_fill() <= bccd_pkg::HDR_BYTES) break;
            if (ring_at(0) == bccd_pkg::HDR_MARK && ring_at(1) == bccd_pkg::HDR_MARK) begin
               total = {ring_at(8), ring_at(9)} + bccd_pkg::FRAME_EXTRA;
               if (total <= bccd_pkg::RING_DEPTH - 1) begin
                  in_frame = 1'b1;
                  frame_bytes = total;
                  wait_ticks = 0;
               end
            end
            if (!in_frame) rd_ptr = (rd_ptr + 1) % bccd_pkg::RING_DEPTH;
         end else if (ring_fill() >= frame_bytes) begin
            in_frame = 1'b0;
            bcc = '0;
            for (i = 2; i + 1 < frame_bytes; i++) bcc ^= ring_at(i);
            if (bcc == ring_at(frame_bytes - 1) && frames < bccd_pkg::MAX_FRAMES) begin
               code = ring_at(2);
               seq = ring_at(7);
               declared = {ring_at(3), ring_at(4), ring_at(5), ring_at(6)};
               inseq = 0; done = 0; over = 0;
               if (code == image_code_cfg) begin
                  sum = {1'b0, image_count};
                  if (seq == last_seq + 8'd1) begin
                     sum += 33'(frame_bytes - bccd_pkg::FRAME_EXTRA);
                     last_seq = seq;
                     inseq = 1;
                  end
                  if (sum == {1'b0, declared}) begin
                     done = 1;
                     image_count = '0;
                  end else if (sum > {1'b0, declared}) begin
                     over = 1;
                     image_count = '0;
                  end else begin
                     image_count = sum[31:0];
                  end
               end
               rd_ptr = (rd_ptr + frame_bytes) % bccd_pkg::RING_DEPTH;
               res.kind = bccd_pkg::KIND_FRAME;
               res.last_flag = 1'b0;
               res.data = '0;
               res.data[7:0] = code;
               res.data[15:8] = seq;
               res.data[47:16] = declared;
               res.data[56:48] = 9'(frame_bytes - bccd_pkg::FRAME_EXTRA);
               res.data[59:57] = {over, done, inseq};
               expected_results.push_back(res);
               frames++;
            end else begin
               if (bcc != ring_at(frame_bytes - 1)) fail_count = sat_add(fail_count);
               rd_ptr = (rd_ptr + 1) % bccd_pkg::RING_DEPTH;
            end
         end else if (wait_ticks < timeout_cfg) begin
            wait_ticks++;
            break;
         end else begin
            in_frame = 1'b0;
            drop_count = sat_add(drop_count);
            rd_ptr = (rd_ptr + 1) % bccd_pkg::RING_DEPTH;
         end
      end
      res.kind = bccd_pkg::KIND_STATUS;
      res.last_flag = 1'b1;
      res.data = '0;
      res.data[67:60] = fail_count;
      res.data[75:68] = drop_count;
      res.data[76] = overflow_flag;
      expected_results.push_back(res);
      fail_count = '0;
      drop_count = '0;
      overflow_flag = 1'b0;
   endtask

   task automatic send_item(input logic command, input logic [7:0] value);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= command;
      req_tdata <= value;
      do @(posedge clock); while (!req_tready);
      if (command == bccd_pkg::CMD_TICK) begin
         predict_scan();
      end else if (ring_fill() >= bccd_pkg::RING_DEPTH - 1) begin
         overflow_flag = 1'b1;
      end else begin
         ring_mem[wr_ptr] = value;
         wr_ptr = (wr_ptr + 1) % bccd_pkg::RING_DEPTH;
      end
   endtask

   task automatic wait_idle();
      if (req_tvalid) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [7:0] value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (index == bccd_pkg::CSR_TIMEOUT) timeout_cfg = value;
      else image_code_cfg = value;
   endtask

   // Sends a frame; keep_bytes below the full length truncates it.
   task automatic send_frame(input logic [7:0] code, input logic [31:0] declared,
                             input logic [7:0] seq, input logic [15:0] plen,
                             input bit bad_bcc, input int keep_bytes);
      logic [7:0] bytes[$];
      logic [7:0] bcc;
      int         i;
      bytes = {bccd_pkg::HDR_MARK, bccd_pkg::HDR_MARK, code, declared[31:24],
               declared[23:16], declared[15:8], declared[7:0], seq, plen[15:8], plen[7:0]};
      for (i = 0; i < plen; i++) bytes.push_back(8'($urandom));
      bcc = '0;
      for (i = 2; i < bytes.size(); i++) bcc ^= bytes[i];
      bytes.push_back(bad_bcc ? ~bcc : bcc);
      for (i = 0; i < bytes.size() && i < keep_bytes; i++)
         send_item(bccd_pkg::CMD_BYTE, bytes[i]);
   endtask

   task automatic send_image_frame(input logic [15:0] plen, input logic [31:0] declared);
      send_frame(image_code_cfg, declared, next_seq, plen, 1'b0, 1 << 20);
      next_seq++;
   endtask

   task automatic test_directed_frames();
      write_csr(bccd_pkg::CSR_TIMEOUT, 8'd255);
      write_csr(bccd_pkg::CSR_IMAGE_CODE, 8'hFF);
      next_seq = 8'd1;
      send_image_frame(16'd0, 32'd0);
      send_image_frame(16'd5, 32'd10);
      send_item(bccd_pkg::CMD_TICK, 8'h00);
      send_image_frame(16'd5, 32'd10);
      send_image_frame(16'd3, 32'hFFFF_FFFF);
      send_frame(8'h00, 32'h8000_0001, 8'hAA, 16'd2, 1'b0, 1 << 20);
      send_frame(8'hFF, 32'd1, 8'h55, 16'd1, 1'b1, 1 << 20);
      send_item(bccd_pkg::CMD_TICK, 8'hFF);
      send_image_frame(16'd9, 32'd4);
      send_item(bccd_pkg::CMD_TICK, 8'h00);
   endtask

   task automatic test_resync();
      write_csr(bccd_pkg::CSR_TIMEOUT, 8'd0);
      write_csr(bccd_pkg::CSR_IMAGE_CODE, 8'h00);
      send_frame(8'h11, 32'd0, 8'd0, 16'd30, 1'b0, 12);
      send_item(bccd_pkg::CMD_TICK, 8'h00);
      send_frame(8'h12, 32'd0, 8'd0, 16'd600, 1'b0, 12);
      send_item(bccd_pkg::CMD_TICK, 8'h00);
      write_csr(bccd_pkg::CSR_TIMEOUT, 8'd3);
      send_frame(8'h13, 32'd0, 8'd0, 16'd40, 1'b0, 14);
      repeat (6) send_item(bccd_pkg::CMD_TICK, 8'h00);
      send_item(bccd_pkg::CMD_TICK, 8'h00);
   endtask

   // Fills the ring with short frames and then random bytes until it overflows.
   task automatic test_ring_overflow();
      int i;
      for (i = 0; i < 45; i++) send_frame(8'h77, 32'd0, 8'd0, 16'd0, 1'b0, 1 << 20);
      for (i = 0; i < 20; i++) send_item(bccd_pkg::CMD_BYTE, 8'($urandom));
      repeat (4) send_item(bccd_pkg::CMD_TICK, 8'h00);
      wait_idle();
   endtask

   task automatic test_backpressure();
      fork
         begin
            hold_results = 1'b1;
            repeat (3000) @(posedge clock);
            hold_results = 1'b0;
         end
         begin
            repeat (6) begin
               send_image_frame(16'($urandom_range(0, 6)), 32'($urandom_range(0, 30)));
               send_item(bccd_pkg::CMD_TICK, 8'h00);
            end
         end
      join
      wait_idle();
   endtask

   task automatic test_random_traffic();
      int sent, choice, i, plen, keep;
      logic [7:0] code;
      write_csr(bccd_pkg::CSR_TIMEOUT, 8'($urandom_range(1, 6)));
      write_csr(bccd_pkg::CSR_IMAGE_CODE, 8'($urandom));
      sent = 0;
      while (sent < 100) begin
         choice = $urandom_range(0, 99);
         plen = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120) : $urandom_range(0, 12);
         code = ($urandom_range(0, 3) == 0) ? 8'($urandom) : image_code_cfg;
         if (choice < 70) begin
            if ($urandom_range(0, 5) == 0) next_seq = 8'($urandom);
            send_frame(code, ($urandom_range(0, 4) == 0) ? 32'($urandom) :
                       32'($urandom_range(0, 40)), next_seq, 16'(plen),
                       ($urandom_range(0, 9) == 0), 1 << 20);
            if (code == image_code_cfg) next_seq++;
            sent += plen + bccd_pkg::FRAME_EXTRA;
         end else if (choice < 80) begin
            for (i = 0; i < 5; i++) send_item(bccd_pkg::CMD_BYTE, 8'($urandom));
            sent += 5;
         end else if (choice < 88) begin
            keep = $urandom_range(2, plen + 10);
            send_frame(code, 32'd0, next_seq, 16'(plen), 1'b0, keep);
            sent += keep;
         end else begin
            send_item(bccd_pkg::CMD_TICK, 8'($urandom));
            sent++;
         end
         if ($urandom_range(0, 2) == 0) begin
            send_item(bccd_pkg::CMD_TICK, 8'($urandom));
            sent++;
         end
         if (sent > 40 && sent < 60) begin
            write_csr(bccd_pkg::CSR_TIMEOUT, 8'($urandom_range(0, 4)));
            write_csr(bccd_pkg::CSR_IMAGE_CODE, 8'($urandom));
            sent = 60;
         end
      end
      repeat (8) send_item(bccd_pkg::CMD_TICK, 8'h00);
   endtask

   initial begin
      wr_ptr = 0; rd_ptr = 0; frame_bytes = 0; wait_ticks = 0;
      in_frame = 0; overflow_flag = 0; image_count = '0; last_seq = '0;
      fail_count = '0; drop_count = '0;
      timeout_cfg = bccd_pkg::TIMEOUT_RESET; image_code_cfg = 8'h00; next_seq = 8'd1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      send_frame(8'h00, 32'd0, 8'd1, 16'd1, 1'b0, 1 << 20);
      send_item(bccd_pkg::CMD_TICK, 8'h00);
      next_seq = last_seq + 8'd1;
      test_directed_frames();
      next_seq = last_seq + 8'd1;
      test_resync();
      test_ring_overflow();
      next_seq = last_seq + 8'd1;
      test_backpressure();
      next_seq = last_seq + 8'd1;
      test_random_traffic();
      wait_idle();
      if (error_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule
